// ----- design/linear_svm_score_and_pvalue_macros.svh -----
// Assertion macros for the linear SVM scorer checker.
`ifndef LINEAR_SVM_SCORE_AND_PVALUE_MACROS_SVH
`define LINEAR_SVM_SCORE_AND_PVALUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LSVM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LSVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lsvm_pkg.sv -----
// Shared types, constants and tables for the linear SVM scorer.
`timescale 1ns / 1ps
package lsvm_pkg;

  localparam int NUM_FEAT  = 8;
  localparam int W_W       = 16;
  localparam int BIAS_W    = 24;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int PE_W   = 20;
  localparam int Z_W    = 16;
  localparam int ALEN_W = 14;

  localparam int X_W    = 24;  // centred feature
  localparam int RCP_W  = 25;
  localparam int P_W    = 42;  // centred * reciprocal
  localparam int LO_W   = 21;
  localparam int HI_W   = P_W - LO_W;
  localparam int SUM_W  = 64;
  localparam int FRAC_SH = 34;
  localparam int BIAS_SH = 32;
  localparam int Q_W    = SUM_W - FRAC_SH;

  localparam int SCORE_W = 24;
  localparam int PROB_W  = 25;
  localparam int CONF_W  = 3;

  localparam int SC_STAGES = 8;

  localparam int E_W   = 41;  // exponent, Q.24
  localparam int FR_W  = 24;
  localparam int V_W   = 31;  // mantissa, Q.30
  localparam int F_W   = 30;
  localparam int F_SH  = 30;
  localparam int MAX_TABLE_BITS = 12;
  localparam int IP_W  = 6;
  localparam int IP_LIMIT = 34;
  localparam int SH_BASE  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_BIAS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_W12  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W34  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W56  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W78  = 3'd4;

  localparam logic [BIAS_W-1:0] BIAS_RST = 24'd36710;
  localparam logic [CFG_W-1:0]  W12_RST  = 32'hFE94_F000;
  localparam logic [CFG_W-1:0]  W34_RST  = 32'hF53F_EDF0;
  localparam logic [CFG_W-1:0]  W56_RST  = 32'h0569_55BD;
  localparam logic [CFG_W-1:0]  W78_RST  = 32'h0053_0000;

  localparam logic [CONF_W-1:0] CONF_CERT  = 3'd0;
  localparam logic [CONF_W-1:0] CONF_HIGH  = 3'd1;
  localparam logic [CONF_W-1:0] CONF_MED   = 3'd2;
  localparam logic [CONF_W-1:0] CONF_LOW   = 3'd3;
  localparam logic [CONF_W-1:0] CONF_GUESS = 3'd4;

  typedef logic signed [W_W-1:0]     weight_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [PROB_W-1:0]         prob_t;
  typedef logic [CONF_W-1:0]         conf_t;

  // Feature centres in Q.8; z features are not centred.
  localparam logic signed [X_W-1:0] CTR_Q8 [NUM_FEAT] = '{
    -24'sd30173, 24'sd0, -24'sd376, 24'sd0,
    24'sd31946, 24'sd28751, 24'sd67059, 24'sd41170
  };

  // round(2^24 / scale); z features use 1.0.
  localparam logic [RCP_W-1:0] RCP_Q24 [NUM_FEAT] = '{
    25'd170111, 25'd16777216, 25'd4162048, 25'd16777216,
    25'd112721, 25'd287360, 25'd92662, 25'd211534
  };

  // 2^(-2^-(j+1)) in Q.30
  localparam logic [F_W-1:0] POW_FRAC_Q30 [MAX_TABLE_BITS] = '{
    30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218693,
    30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
    30'd1072289172, 30'd1073015252, 30'd1073378477, 30'd1073560134
  };

  // Probability band limits: 1e-4, 1e-3, 1e-2, 1e-1 in Q1.24
  localparam logic [PROB_W-1:0] BAND_LIM [4] = '{
    25'd1678, 25'd16778, 25'd167773, 25'd1677722
  };

  localparam logic signed [E_W-1:0]    K_Q24      = 41'sd95075846;
  localparam logic signed [W_W-1:0]    M_Q16      = 16'sd21985;
  localparam logic [V_W-1:0]           ONE_Q30    = 31'h4000_0000;
  localparam logic [V_W+F_W-1:0]       HALF_Q30   = 61'h2000_0000;
  localparam logic [PROB_W-1:0]        PROB_ONE   = 25'd16777216;
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = 64'sh2_0000_0000;
  localparam logic signed [Q_W-1:0]    SCORE_MAX_Q = 30'sd8388607;
  localparam logic signed [Q_W-1:0]    SCORE_MIN_Q = -30'sd8388608;
  localparam logic [ALEN_W-1:0]        MIN_ALIGN  = 14'd20;

endpackage

// ----- design/linear_svm_score_and_pvalue.sv -----
// Top level: linear SVM hit scorer with calibrated probability and class.
// Throughput: one hit per cycle unless out_stall backs up a full pipeline; every stage is
// registered and carries its own valid. The depth is set by the adder tree and the chain
// of EXP_TABLE_BITS factor multiplies.
// rst (synchronous, active high) empties the pipeline and loads the default model.
`timescale 1ns / 1ps
module linear_svm_score_and_pvalue #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [lsvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsvm_pkg::CFG_W-1:0]          cfg_data,
  // hit input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lsvm_pkg::PE_W-1:0]    pair_energy,
  input  logic signed [lsvm_pkg::Z_W-1:0]     pair_zscore,
  input  logic signed [lsvm_pkg::Z_W-1:0]     solvation_energy,
  input  logic signed [lsvm_pkg::Z_W-1:0]     solvation_zscore,
  input  logic signed [lsvm_pkg::PE_W-1:0]    align_score,
  input  logic [lsvm_pkg::ALEN_W-1:0]         align_length,
  input  logic [lsvm_pkg::ALEN_W-1:0]         query_length,
  input  logic [lsvm_pkg::ALEN_W-1:0]         template_length,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output lsvm_pkg::score_t                    score,
  output lsvm_pkg::prob_t                     probability,
  output lsvm_pkg::conf_t                     confidence
);
  import lsvm_pkg::*;

  localparam int PR_STAGES = EXP_TABLE_BITS + 4;
  localparam int N_STAGES  = SC_STAGES + PR_STAGES;

  logic [BIAS_W-1:0]   bias_q;
  logic [CFG_W-1:0]    w12_q;
  logic [CFG_W-1:0]    w34_q;
  logic [CFG_W-1:0]    w56_q;
  logic [CFG_W-1:0]    w78_q;
  weight_t             w [NUM_FEAT];

  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] en;
  score_t              score_mid;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_q <= BIAS_RST;
      w12_q  <= W12_RST;
      w34_q  <= W34_RST;
      w56_q  <= W56_RST;
      w78_q  <= W78_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIAS: bias_q <= cfg_data[BIAS_W-1:0];
        REG_W12:  w12_q  <= cfg_data;
        REG_W34:  w34_q  <= cfg_data;
        REG_W56:  w56_q  <= cfg_data;
        REG_W78:  w78_q  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each register holds two Q5.10 weights, low half first
  assign w[0] = w12_q[W_W-1:0];
  assign w[1] = w12_q[CFG_W-1:W_W];
  assign w[2] = w34_q[W_W-1:0];
  assign w[3] = w34_q[CFG_W-1:W_W];
  assign w[4] = w56_q[W_W-1:0];
  assign w[5] = w56_q[CFG_W-1:W_W];
  assign w[6] = w78_q[W_W-1:0];
  assign w[7] = w78_q[CFG_W-1:W_W];

  // Stage k may load when the output is not held or some stage at or after
  // it is empty. This collapses bubbles, so the input keeps taking hits
  // while a result waits at the output, until every stage is full.
  for (genvar k = 0; k < N_STAGES; k++) begin : g_en
    assign en[k] = !out_stall || !(&vld[N_STAGES-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[N_STAGES-1];

  // Score: centre/scale/weight per feature, then a registered sum tree
  lsvm_score u_score (
    .clk              (clk),
    .en               (en[SC_STAGES-1:0]),
    .pair_energy      (pair_energy),
    .pair_zscore      (pair_zscore),
    .solvation_energy (solvation_energy),
    .solvation_zscore (solvation_zscore),
    .align_score      (align_score),
    .align_length     (align_length),
    .query_length     (query_length),
    .template_length  (template_length),
    .w                (w),
    .bias             (bias_q),
    .score            (score_mid)
  );

  // Probability 2^(K - M*score) and confidence class
  lsvm_prob #(
    .TB (EXP_TABLE_BITS)
  ) u_prob (
    .clk         (clk),
    .en          (en[N_STAGES-1:SC_STAGES]),
    .score_in    (score_mid),
    .score       (score),
    .probability (probability),
    .confidence  (confidence)
  );

endmodule

// ----- design/lsvm_score.sv -----
// Score datapath: centring, scaling, weighting, adder tree, rounding, short-alignment override.
`timescale 1ns / 1ps
module lsvm_score (
  input  logic                                clk,
  input  logic [lsvm_pkg::SC_STAGES-1:0]      en,
  input  logic signed [lsvm_pkg::PE_W-1:0]    pair_energy,
  input  logic signed [lsvm_pkg::Z_W-1:0]     pair_zscore,
  input  logic signed [lsvm_pkg::Z_W-1:0]     solvation_energy,
  input  logic signed [lsvm_pkg::Z_W-1:0]     solvation_zscore,
  input  logic signed [lsvm_pkg::PE_W-1:0]    align_score,
  input  logic [lsvm_pkg::ALEN_W-1:0]         align_length,
  input  logic [lsvm_pkg::ALEN_W-1:0]         query_length,
  input  logic [lsvm_pkg::ALEN_W-1:0]         template_length,
  input  lsvm_pkg::weight_t                   w [lsvm_pkg::NUM_FEAT],
  input  logic signed [lsvm_pkg::BIAS_W-1:0]  bias,
  output lsvm_pkg::score_t                    score
);
  import lsvm_pkg::*;

  localparam int SHORT_STAGES = SC_STAGES - 1;
  localparam int SV_W = 5;

  logic signed [X_W-1:0]            x      [NUM_FEAT];
  logic signed [X_W-1:0]            diff_q [NUM_FEAT];
  logic signed [X_W+RCP_W:0]        prod_full [NUM_FEAT];
  logic signed [P_W-1:0]            prod_q [NUM_FEAT];
  logic signed [LO_W+W_W:0]         mlo_q  [NUM_FEAT];
  logic signed [HI_W+W_W-1:0]       mhi_q  [NUM_FEAT];
  logic signed [SUM_W-1:0]          term_q [NUM_FEAT];
  logic signed [SUM_W-1:0]          s4_q   [4];
  logic signed [SUM_W-1:0]          s5_q   [2];
  logic signed [SUM_W-1:0]          total_q;
  logic signed [SUM_W-1:0]          rnd;
  logic signed [Q_W-1:0]            q_score;
  score_t                           sat_score;
  logic                             short_q [SHORT_STAGES];
  logic [SV_W-1:0]                  sval_q  [SHORT_STAGES];

  // Integer lengths move to Q.8
  always_comb begin
    x[0] = X_W'(pair_energy);
    x[1] = X_W'(pair_zscore);
    x[2] = X_W'(solvation_energy);
    x[3] = X_W'(solvation_zscore);
    x[4] = X_W'(align_score);
    x[5] = $signed(X_W'({align_length, 8'b0}));
    x[6] = $signed(X_W'({query_length, 8'b0}));
    x[7] = $signed(X_W'({template_length, 8'b0}));
  end

  always_comb begin
    for (int i = 0; i < NUM_FEAT; i++) begin
      prod_full[i] = diff_q[i] * $signed({1'b0, RCP_Q24[i]});
    end
  end

  // Stages 0..3: per-lane datapath; the weight product is split in two halves
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_FEAT; i++) begin
      if (en[0]) begin
        diff_q[i] <= x[i] - CTR_Q8[i];
      end
      if (en[1]) begin
        prod_q[i] <= prod_full[i][P_W-1:0];
      end
      if (en[2]) begin
        mlo_q[i] <= $signed({1'b0, prod_q[i][LO_W-1:0]}) * w[i];
        mhi_q[i] <= $signed(prod_q[i][P_W-1:LO_W]) * w[i];
      end
      if (en[3]) begin
        term_q[i] <= (SUM_W'(mhi_q[i]) <<< LO_W) + SUM_W'(mlo_q[i]);
      end
    end
  end

  // Stages 4..6: adder tree, bias joins at the last level
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 4; k++) begin
        s4_q[k] <= term_q[2*k] + term_q[2*k+1];
      end
    end
    if (en[5]) begin
      for (int k = 0; k < 2; k++) begin
        s5_q[k] <= s4_q[2*k] + s4_q[2*k+1];
      end
    end
    if (en[6]) begin
      total_q <= s5_q[0] + s5_q[1] + (SUM_W'(bias) <<< BIAS_SH);
    end
  end

  // Round half up to Q.8 and saturate
  always_comb begin
    rnd     = total_q + ROUND_HALF;
    q_score = rnd[SUM_W-1:FRAC_SH];
    if (q_score > SCORE_MAX_Q) begin
      sat_score = SCORE_MAX_Q[SCORE_W-1:0];
    end else if (q_score < SCORE_MIN_Q) begin
      sat_score = SCORE_MIN_Q[SCORE_W-1:0];
    end else begin
      sat_score = q_score[SCORE_W-1:0];
    end
  end

  // Short-alignment flag rides alongside the arithmetic
  always_ff @(posedge clk) begin
    if (en[0]) begin
      short_q[0] <= align_length < MIN_ALIGN;
      sval_q[0]  <= align_length[SV_W-1:0];
    end
    for (int k = 1; k < SHORT_STAGES; k++) begin
      if (en[k]) begin
        short_q[k] <= short_q[k-1];
        sval_q[k]  <= sval_q[k-1];
      end
    end
    if (en[SC_STAGES-1]) begin
      score <= short_q[SHORT_STAGES-1] ?
               $signed(SCORE_W'({sval_q[SHORT_STAGES-1], 8'b0})) : sat_score;
    end
  end

endmodule

// ----- design/lsvm_prob.sv -----
// Probability datapath: exponent, 2^-fraction factor chain, shift, banding.
`timescale 1ns / 1ps
module lsvm_prob #(
  parameter int TB = 8
) (
  input  logic              clk,
  input  logic [TB+3:0]     en,
  input  lsvm_pkg::score_t  score_in,
  output lsvm_pkg::score_t  score,
  output lsvm_pkg::prob_t   probability,
  output lsvm_pkg::conf_t   confidence
);
  import lsvm_pkg::*;

  typedef struct packed {
    score_t          sc;
    logic            pos;
    logic            big;
    logic [IP_W-1:0] ip;
    logic [TB-1:0]   idx;
  } aux_t;

  logic signed [SCORE_W-1:0]      sc0_q;
  logic signed [SCORE_W+W_W-1:0]  prodm_q;
  logic signed [E_W-1:0]          e;
  logic [E_W-1:0]                 n;
  logic [E_W-FR_W-1:0]            ip_full;
  aux_t                           aux_q [TB+1];
  logic [V_W-1:0]                 v_q [TB];
  logic [IP_W-1:0]                sh;
  logic [E_W-1:0]                 shv;
  logic [E_W-1:0]                 p_wide;
  prob_t                          p_next;
  prob_t                          p_q;
  score_t                         sc_s_q;
  conf_t                          conf_next;

  always_comb begin
    e       = K_Q24 - E_W'(prodm_q);
    n       = -e;
    ip_full = n[E_W-1:FR_W];
  end

  // Stages 0 and 1: slope product, then exponent split
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sc0_q   <= score_in;
      prodm_q <= score_in * M_Q16;
    end
    if (en[1]) begin
      aux_q[0].sc  <= sc0_q;
      aux_q[0].pos <= e >= 0;
      aux_q[0].big <= ip_full >= (E_W-FR_W)'(IP_LIMIT);
      aux_q[0].ip  <= ip_full[IP_W-1:0];
      aux_q[0].idx <= n[FR_W-1 -: TB];
    end
  end

  // One factor per stage, MSB of the fraction index first
  for (genvar j = 0; j < TB; j++) begin : g_fac
    logic [V_W-1:0]     vin;
    logic [V_W+F_W-1:0] prodv;
    logic [V_W+F_W-1:0] rndv;

    if (j == 0) begin : g_first
      assign vin = ONE_Q30;
    end else begin : g_rest
      assign vin = v_q[j-1];
    end

    assign prodv = vin * POW_FRAC_Q30[j];
    assign rndv  = prodv + HALF_Q30;

    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        v_q[j]     <= aux_q[j].idx[TB-1-j] ? rndv[V_W+F_SH-1:F_SH] : vin;
        aux_q[j+1] <= aux_q[j];
      end
    end
  end

  // Integer part of the exponent becomes a rounded right shift
  always_comb begin
    sh     = IP_W'(SH_BASE) + aux_q[TB].ip;
    shv    = E_W'(1) << (sh - IP_W'(1));
    p_wide = (E_W'(v_q[TB-1]) + shv) >> sh;
    if (aux_q[TB].pos) begin
      p_next = PROB_ONE;
    end else if (aux_q[TB].big) begin
      p_next = '0;
    end else if (p_wide > E_W'(PROB_ONE)) begin
      p_next = PROB_ONE;
    end else begin
      p_next = p_wide[PROB_W-1:0];
    end
  end

  always_comb begin
    priority if (p_q < BAND_LIM[0]) begin
      conf_next = CONF_CERT;
    end else if (p_q < BAND_LIM[1]) begin
      conf_next = CONF_HIGH;
    end else if (p_q < BAND_LIM[2]) begin
      conf_next = CONF_MED;
    end else if (p_q < BAND_LIM[3]) begin
      conf_next = CONF_LOW;
    end else begin
      conf_next = CONF_GUESS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[TB+2]) begin
      p_q    <= p_next;
      sc_s_q <= aux_q[TB].sc;
    end
    if (en[TB+3]) begin
      score       <= sc_s_q;
      probability <= p_q;
      confidence  <= conf_next;
    end
  end

endmodule

// ----- design/lsvm_checker.sv -----
// Port-level checker for the linear SVM scorer, bound to the top level.
`timescale 1ns / 1ps
`include "linear_svm_score_and_pvalue_macros.svh"
module lsvm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input lsvm_pkg::score_t                    score,
  input lsvm_pkg::prob_t                     probability,
  input lsvm_pkg::conf_t                     confidence
);
  import lsvm_pkg::*;

  logic                               held;
  logic [SCORE_W+PROB_W+CONF_W-1:0]   res;
  logic                               top_band;
  logic                               low_band;

  assign held     = out_valid && out_stall;
  assign res      = {score, probability, confidence};
  assign top_band = probability >= BAND_LIM[3];
  assign low_band = probability < BAND_LIM[0];

  `LSVM_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(res), "held result changed")

  `LSVM_ASSERT_IMPLY(a_prob_max, out_valid, probability <= PROB_ONE, "probability above one")

  `LSVM_ASSERT_IMPLY(a_band_top, out_valid && top_band, confidence == CONF_GUESS, "bad top band")

  `LSVM_ASSERT_IMPLY(a_band_low, out_valid && low_band, confidence == CONF_CERT, "bad bottom band")

  `LSVM_ASSERT_IMPLY(a_empty_takes, !out_valid, !in_stall, "input stalled with empty output stage")

endmodule

bind linear_svm_score_and_pvalue lsvm_checker u_lsvm_checker (.*);
